// ===== rtl/i2c_rts_pkg.sv =====
package i2c_rts_pkg;

  // Default widths of the transfer counter and the reply timer.
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned TIMEOUT_BITS_DEF = 24;

  // Timeout limit after reset, in ticks.
  localparam logic [31:0] TIMEOUT_RESET = 32'd100000;

  // Result buffer geometry.
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_PAYLOAD = 3'd2,
    FN_REPLY   = 3'd3,
    FN_TICK    = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    OP_WAIT_IDLE = 4'd0,
    OP_START     = 4'd1,
    OP_SEND      = 4'd2,
    OP_READ_ACK  = 4'd3,
    OP_READ_NACK = 4'd4,
    OP_WAIT_DONE = 4'd5,
    OP_STOP      = 4'd6,
    OP_REPORT    = 4'd7,
    OP_NEED_PAY  = 4'd8,
    OP_DATA_OUT  = 4'd9
  } bus_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [15:0] byte_count;
    logic [7:0]  payload_byte;
    logic        reply_status;
    logic [7:0]  read_byte;
  } in_item_t;

  typedef struct packed {
    bus_op_e     op;
    logic [7:0]  data;
    status_e     status;
    logic        last;
  } res_t;

  // Up to three results produced by one item, entry 0 first.
  typedef struct packed {
    logic [1:0]           num;
    res_t [MAX_RES-1:0]   ent;
  } bundle_t;

  function automatic res_t mk_res(bus_op_e op, logic [7:0] data, status_e st);
    res_t r;
    r.op     = op;
    r.data   = data;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/i2c_rts_if.sv =====
interface i2c_rts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  device_address;
  logic [15:0] register_address;
  logic [15:0] byte_count;
  logic [7:0]  payload_byte;
  logic        reply_status;
  logic [7:0]  read_byte;

  modport source (
    output valid, func, device_address, register_address, byte_count,
           payload_byte, reply_status, read_byte,
    input  ready
  );
  modport sink (
    input  valid, func, device_address, register_address, byte_count,
           payload_byte, reply_status, read_byte,
    output ready
  );
endinterface

interface i2c_rts_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] bus_op;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, bus_op, out_byte, status, last,
    input  ready
  );
  modport sink (
    input  valid, bus_op, out_byte, status, last,
    output ready
  );
endinterface

// ===== rtl/i2c_rts_seq.sv =====
module i2c_rts_seq #(
  parameter int unsigned COUNT_BITS   = i2c_rts_pkg::COUNT_BITS_DEF,
  parameter int unsigned TIMEOUT_BITS = i2c_rts_pkg::TIMEOUT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [TIMEOUT_BITS-1:0]   cfg_wdata_i,
  input  logic                      accept_i,
  input  i2c_rts_pkg::in_item_t     item_i,
  output i2c_rts_pkg::bundle_t      bundle_o
);
  import i2c_rts_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WBUSY, PH_START1, PH_ADDRW, PH_REGHI, PH_REGLO,
    PH_NEEDPAY, PH_SENDDATA, PH_WDONE, PH_START2, PH_ADDRR, PH_READING
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [6:0]                tgt_q, tgt_d;
  logic [15:0]               reg_q, reg_d;
  logic [COUNT_BITS-1:0]     left_q, left_d;
  logic                      is_read_q, is_read_d;
  logic [TIMEOUT_BITS-1:0]   wait_q, wait_d;
  logic [TIMEOUT_BITS-1:0]   limit_q;

  logic [COUNT_BITS-1:0]     left_new;
  logic [COUNT_BITS-1:0]     left_dec;
  logic [TIMEOUT_BITS-1:0]   wait_inc;
  logic                      waiting;
  logic [1:0]                num;
  logic [1:0]                num_m1;
  res_t [MAX_RES-1:0]        res;

  assign left_new = COUNT_BITS'(item_i.byte_count);
  assign left_dec = left_q - COUNT_BITS'(1);
  assign wait_inc = wait_q + TIMEOUT_BITS'(1);
  assign waiting  = (phase_q != PH_IDLE) && (phase_q != PH_NEEDPAY);
  assign num_m1   = num - 2'd1;

  always_comb begin
    phase_d   = phase_q;
    tgt_d     = tgt_q;
    reg_d     = reg_q;
    left_d    = left_q;
    is_read_d = is_read_q;
    wait_d    = wait_q;
    num       = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = mk_res(OP_WAIT_IDLE, 8'h00, ST_OK);
    end

    case (item_i.func)
      FN_WRITE, FN_READ: begin
        if (phase_q == PH_IDLE) begin
          tgt_d     = item_i.device_address;
          reg_d     = item_i.register_address;
          left_d    = left_new;
          is_read_d = (item_i.func == FN_READ);
          if ((item_i.func == FN_READ) && (left_new == '0)) begin
            res[0] = mk_res(OP_REPORT, 8'h00, ST_INVALID);
            num    = 2'd1;
          end else begin
            phase_d = PH_WBUSY;
            wait_d  = '0;
            res[0]  = mk_res(OP_WAIT_IDLE, 8'h00, ST_OK);
            num     = 2'd1;
          end
        end
      end
      FN_PAYLOAD: begin
        if (phase_q == PH_NEEDPAY) begin
          left_d  = left_dec;
          phase_d = PH_SENDDATA;
          wait_d  = '0;
          res[0]  = mk_res(OP_SEND, item_i.payload_byte, ST_OK);
          num     = 2'd1;
        end
      end
      FN_REPLY: begin
        if (waiting && !item_i.reply_status) begin
          wait_d = '0;
          num    = 2'd1;
          case (phase_q)
            PH_WBUSY: begin
              phase_d = PH_START1;
              res[0]  = mk_res(OP_START, 8'h00, ST_OK);
            end
            PH_START1: begin
              phase_d = PH_ADDRW;
              res[0]  = mk_res(OP_SEND, {tgt_q, 1'b0}, ST_OK);
            end
            PH_ADDRW: begin
              phase_d = PH_REGHI;
              res[0]  = mk_res(OP_SEND, reg_q[15:8], ST_OK);
            end
            PH_REGHI: begin
              phase_d = PH_REGLO;
              res[0]  = mk_res(OP_SEND, reg_q[7:0], ST_OK);
            end
            PH_REGLO, PH_SENDDATA: begin
              if (is_read_q && (phase_q == PH_REGLO)) begin
                phase_d = PH_START2;
                res[0]  = mk_res(OP_START, 8'h00, ST_OK);
              end else if (left_q == '0) begin
                phase_d = PH_WDONE;
                res[0]  = mk_res(OP_WAIT_DONE, 8'h00, ST_OK);
              end else begin
                // Payload requests leave the reply timer as it stands.
                phase_d = PH_NEEDPAY;
                wait_d  = wait_q;
                res[0]  = mk_res(OP_NEED_PAY, 8'h00, ST_OK);
              end
            end
            PH_WDONE: begin
              phase_d = PH_IDLE;
              res[0]  = mk_res(OP_STOP, 8'h00, ST_OK);
              res[1]  = mk_res(OP_REPORT, 8'h00, ST_OK);
              num     = 2'd2;
            end
            PH_START2: begin
              phase_d = PH_ADDRR;
              res[0]  = mk_res(OP_SEND, {tgt_q, 1'b1}, ST_OK);
            end
            PH_ADDRR: begin
              phase_d = PH_READING;
              res[0]  = mk_res((left_q == COUNT_BITS'(1)) ? OP_READ_NACK : OP_READ_ACK,
                               8'h00, ST_OK);
            end
            PH_READING: begin
              left_d = left_dec;
              res[0] = mk_res(OP_DATA_OUT, item_i.read_byte, ST_OK);
              if (left_dec == '0) begin
                phase_d = PH_IDLE;
                res[1]  = mk_res(OP_STOP, 8'h00, ST_OK);
                res[2]  = mk_res(OP_REPORT, 8'h00, ST_OK);
                num     = 2'd3;
              end else begin
                res[1] = mk_res((left_dec == COUNT_BITS'(1)) ? OP_READ_NACK
                                                             : OP_READ_ACK,
                                8'h00, ST_OK);
                num    = 2'd2;
              end
            end
            default: begin
              wait_d = wait_q;
              num    = 2'd0;
            end
          endcase
        end else if (waiting) begin
          // Fault reply: no stop while still waiting for a free bus.
          phase_d = PH_IDLE;
          wait_d  = '0;
          if (phase_q == PH_WBUSY) begin
            res[0] = mk_res(OP_REPORT, 8'h00, ST_ERROR);
            num    = 2'd1;
          end else begin
            res[0] = mk_res(OP_STOP, 8'h00, ST_OK);
            res[1] = mk_res(OP_REPORT, 8'h00,
                            (phase_q == PH_WDONE) ? ST_TIMEOUT : ST_ERROR);
            num    = 2'd2;
          end
        end
      end
      FN_TICK: begin
        if (waiting) begin
          wait_d = wait_inc;
          // A wrap to zero also aborts; a zero limit acts as one, since the first tick already meets it.
          if ((wait_inc >= limit_q) || (wait_inc == '0)) begin
            phase_d = PH_IDLE;
            wait_d  = '0;
            if (phase_q == PH_WBUSY) begin
              res[0] = mk_res(OP_REPORT, 8'h00, ST_TIMEOUT);
              num    = 2'd1;
            end else begin
              res[0] = mk_res(OP_STOP, 8'h00, ST_OK);
              res[1] = mk_res(OP_REPORT, 8'h00,
                              (phase_q == PH_WDONE) ? ST_TIMEOUT : ST_ERROR);
              num    = 2'd2;
            end
          end
        end
      end
      default: begin
        num = 2'd0;
      end
    endcase

    for (int k = 0; k < MAX_RES; k++) begin
      res[k].last = (2'(k) == num_m1);
    end
  end

  assign bundle_o.num = accept_i ? num : 2'd0;
  assign bundle_o.ent = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tgt_q     <= '0;
      reg_q     <= '0;
      left_q    <= '0;
      is_read_q <= 1'b0;
      wait_q    <= '0;
      limit_q   <= TIMEOUT_RESET[TIMEOUT_BITS-1:0];
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q   <= phase_d;
        tgt_q     <= tgt_d;
        reg_q     <= reg_d;
        left_q    <= left_d;
        is_read_q <= is_read_d;
        wait_q    <= wait_d;
      end
    end
  end

endmodule

// ===== rtl/i2c_rts_rbuf.sv =====
module i2c_rts_rbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2c_rts_pkg::bundle_t  push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output i2c_rts_pkg::res_t     head_o
);
  import i2c_rts_pkg::*;

  res_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;
  logic                 pop;

  // Room for a whole bundle of three while one result may still sit here.
  assign room_o  = (cnt_q <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  assign wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.num);
  assign rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
  assign cnt_d    = cnt_q + FIFO_CW'(push_i.num) - FIFO_CW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push_i.num) begin
        mem_q[wr_ptr_q + FIFO_AW'(k)] <= push_i.ent[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/i2c_register_transaction_sequencer_core.sv =====
// Channel  | Dir | Handshake     | Carries
// ---------+-----+---------------+-----------------------------------------------
// req_i    | in  | valid / ready | func, addresses, byte count, payload, reply
// rsp_o    | out | valid / ready | bus_op, out_byte, status, last
// cfg      | in  | cfg_we_i      | timeout_limit, no read-back
//
// An item is taken on a handshake: the sequencer state updates at that edge and its zero
// to three results enter a four-entry result buffer at the same edge, visible next cycle.
// One item per cycle is sustained while each item yields at most one result and the sink
// takes one per cycle; an item with more than one result holds the input until one is left.
// Reset is asynchronous and active low: sequencer idle, buffer empty, default limit loaded.
// req_i.ready drops once fewer than three slots are free; it never depends on rsp_o.ready.
module i2c_register_transaction_sequencer_core #(
  parameter int unsigned COUNT_BITS   = i2c_rts_pkg::COUNT_BITS_DEF,
  parameter int unsigned TIMEOUT_BITS = i2c_rts_pkg::TIMEOUT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [TIMEOUT_BITS-1:0] cfg_wdata_i,
  i2c_rts_req_if.sink             req_i,
  i2c_rts_rsp_if.source           rsp_o
);
  import i2c_rts_pkg::*;

  in_item_t  item;
  bundle_t   bundle;
  res_t      head;
  logic      room;
  logic      accept;

  // Input fields gathered into one item for the sequencer.
  assign item.func             = req_i.func;
  assign item.device_address   = req_i.device_address;
  assign item.register_address = req_i.register_address;
  assign item.byte_count       = req_i.byte_count;
  assign item.payload_byte     = req_i.payload_byte;
  assign item.reply_status     = req_i.reply_status;
  assign item.read_byte        = req_i.read_byte;

  assign req_i.ready = room;
  assign accept      = req_i.valid && room;

  // Decodes the item against the transfer phase and builds its results.
  i2c_rts_seq #(
    .COUNT_BITS   (COUNT_BITS),
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item),
    .bundle_o    (bundle)
  );

  // Holds results and hands them out one per handshake, in order.
  i2c_rts_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bundle),
    .room_o  (room),
    .valid_o (rsp_o.valid),
    .pop_i   (rsp_o.ready),
    .head_o  (head)
  );

  assign rsp_o.bus_op   = head.op;
  assign rsp_o.out_byte = head.data;
  assign rsp_o.status   = head.status;
  assign rsp_o.last     = head.last;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import i2c_rts_pkg::*;

  // Unused function codes. The sequencer must ignore them.
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  // Watchdog limit.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to let pass once nothing is expected, before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Length of the one long stall on the result side.
  localparam int unsigned HOLD_CYCLES = 400;

  // Transfer phases of the sequencer, as the prediction tracks them.
  typedef enum logic [3:0] {
    S_IDLE, S_BUSY_WAIT, S_START, S_ADDR_W, S_REG_HI, S_REG_LO,
    S_NEED_PAY, S_SEND_DATA, S_DONE_WAIT, S_RESTART, S_ADDR_R, S_READING
  } seq_phase_e;

  typedef struct {
    seq_phase_e  phase;
    logic [6:0]  dev;
    logic [15:0] ptr;
    logic [15:0] left;
    logic        rd;
    logic [23:0] ticks;
    logic [23:0] limit;
  } seq_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Everything driven into the block starts at a known value.
  logic                        drv_valid = 1'b0;
  in_item_t                    drv_item = '0;
  logic                        take_ready = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [TIMEOUT_BITS_DEF-1:0] cfg_wdata = '0;

  // When set, neither side idles.
  logic calm = 1'b0;
  // Requests the one long result-side stall; the receiver counts it out itself.
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned failures = 0;

  // Items waiting to be offered, and results waiting to arrive.
  in_item_t queued_items[$];
  res_t     pending_results[$];

  // Two copies of the sequencer state: one follows accepted items and predicts,
  // the other follows the stimulus as it is planned so that well-formed
  // transfers can be built.
  seq_state_t seq_model;
  seq_state_t seq_plan;
  res_t       plan_scratch[$];

  i2c_rts_req_if req_ch ();
  i2c_rts_rsp_if rsp_ch ();

  assign req_ch.valid            = drv_valid;
  assign req_ch.func             = drv_item.func;
  assign req_ch.device_address   = drv_item.device_address;
  assign req_ch.register_address = drv_item.register_address;
  assign req_ch.byte_count       = drv_item.byte_count;
  assign req_ch.payload_byte     = drv_item.payload_byte;
  assign req_ch.reply_status     = drv_item.reply_status;
  assign req_ch.read_byte        = drv_item.read_byte;
  assign rsp_ch.ready            = take_ready;

  i2c_register_transaction_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic seq_state_t reset_state();
    seq_state_t s;
    s.phase = S_IDLE;
    s.dev   = '0;
    s.ptr   = '0;
    s.left  = '0;
    s.rd    = 1'b0;
    s.ticks = '0;
    s.limit = TIMEOUT_RESET[23:0];
    return s;
  endfunction

  function automatic void add_res(ref res_t q[$], input bus_op_e op, input logic [7:0] data,
                                  input status_e st);
    res_t r;
    r.op     = op;
    r.data   = data;
    r.status = st;
    r.last   = 1'b0;
    q.push_back(r);
  endfunction

  // Issue a bus operation that waits for a reply; the reply timer restarts.
  function automatic void enter_wait(ref seq_state_t s, ref res_t q[$], input seq_phase_e ph,
                                     input bus_op_e op, input logic [7:0] data);
    s.phase = ph;
    s.ticks = '0;
    add_res(q, op, data, ST_OK);
  endfunction

  // End the transfer, with a stop on the bus unless nothing was started.
  function automatic void close_out(ref seq_state_t s, ref res_t q[$], input logic with_stop,
                                    input status_e st);
    if (with_stop) add_res(q, OP_STOP, 8'h00, ST_OK);
    add_res(q, OP_REPORT, 8'h00, st);
    s.phase = S_IDLE;
    s.ticks = '0;
  endfunction

  // Applies one item to the state and appends the results it causes to q.
  function automatic void sequencer_step(ref seq_state_t s, input in_item_t it, ref res_t q[$]);
    int   first;
    logic waiting;
    first   = q.size();
    waiting = (s.phase != S_IDLE) && (s.phase != S_NEED_PAY);
    case (it.func)
      FN_WRITE, FN_READ: begin
        if (s.phase == S_IDLE) begin
          s.dev  = it.device_address;
          s.ptr  = it.register_address;
          s.left = it.byte_count;
          s.rd   = (it.func == FN_READ);
          // A read of nothing is refused on the spot and leaves the block idle.
          if (s.rd && s.left == '0) add_res(q, OP_REPORT, 8'h00, ST_INVALID);
          else enter_wait(s, q, S_BUSY_WAIT, OP_WAIT_IDLE, 8'h00);
        end
      end
      FN_PAYLOAD: begin
        if (s.phase == S_NEED_PAY) begin
          s.left = s.left - 1'b1;
          enter_wait(s, q, S_SEND_DATA, OP_SEND, it.payload_byte);
        end
      end
      FN_REPLY: begin
        if (waiting && it.reply_status) begin
          if (s.phase == S_BUSY_WAIT) close_out(s, q, 1'b0, ST_ERROR);
          else if (s.phase == S_DONE_WAIT) close_out(s, q, 1'b1, ST_TIMEOUT);
          else close_out(s, q, 1'b1, ST_ERROR);
        end else if (waiting) begin
          case (s.phase)
            S_BUSY_WAIT: enter_wait(s, q, S_START, OP_START, 8'h00);
            S_START:     enter_wait(s, q, S_ADDR_W, OP_SEND, {s.dev, 1'b0});
            S_ADDR_W:    enter_wait(s, q, S_REG_HI, OP_SEND, s.ptr[15:8]);
            S_REG_HI:    enter_wait(s, q, S_REG_LO, OP_SEND, s.ptr[7:0]);
            S_REG_LO, S_SEND_DATA: begin
              if (s.rd && s.phase == S_REG_LO) begin
                enter_wait(s, q, S_RESTART, OP_START, 8'h00);
              end else if (s.left == '0) begin
                enter_wait(s, q, S_DONE_WAIT, OP_WAIT_DONE, 8'h00);
              end else begin
                s.phase = S_NEED_PAY;
                add_res(q, OP_NEED_PAY, 8'h00, ST_OK);
              end
            end
            S_DONE_WAIT: close_out(s, q, 1'b1, ST_OK);
            S_RESTART:   enter_wait(s, q, S_ADDR_R, OP_SEND, {s.dev, 1'b1});
            S_ADDR_R, S_READING: begin
              if (s.phase == S_READING) begin
                add_res(q, OP_DATA_OUT, it.read_byte, ST_OK);
                s.left = s.left - 1'b1;
              end
              // The last byte of a read is NACKed; the one after it ends the transfer.
              if (s.phase == S_READING && s.left == '0) close_out(s, q, 1'b1, ST_OK);
              else if (s.left == 16'd1) enter_wait(s, q, S_READING, OP_READ_NACK, 8'h00);
              else enter_wait(s, q, S_READING, OP_READ_ACK, 8'h00);
            end
            default: ;
          endcase
        end
      end
      FN_TICK: begin
        if (waiting) begin
          s.ticks = s.ticks + 1'b1;
          if (s.ticks >= s.limit || s.ticks == '0) begin
            if (s.phase == S_BUSY_WAIT) close_out(s, q, 1'b0, ST_TIMEOUT);
            else if (s.phase == S_DONE_WAIT) close_out(s, q, 1'b1, ST_TIMEOUT);
            else close_out(s, q, 1'b1, ST_ERROR);
          end
        end
      end
      default: ;
    endcase
    if (q.size() > first) q[q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, sometimes idling between them.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || req_ch.ready) begin
      if (queued_items.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
        drv_item  <= queued_items.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long stall on request.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      take_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      take_ready <= 1'b0;
    end else begin
      take_ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each delivered result against the oldest prediction, then
  // predicts the results of the item accepted at this edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    res_t want;
    res_t fresh[$];
    if (rst_ni) begin
      if (rsp_ch.valid && take_ready) begin
        if (pending_results.size() == 0) begin
          $error("bus_op %0d delivered with no result expected", rsp_ch.bus_op);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.bus_op !== want.op) begin
            $error("bus_op mismatch: expected %0d, got %0d", want.op, rsp_ch.bus_op);
            failures++;
          end
          if (rsp_ch.out_byte !== want.data) begin
            $error("out_byte mismatch: expected %0d, got %0d", want.data, rsp_ch.out_byte);
            failures++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_ch.status);
            failures++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, rsp_ch.last);
            failures++;
          end
        end
      end
      if (drv_valid && req_ch.ready) begin
        fresh.delete();
        sequencer_step(seq_model, drv_item, fresh);
        foreach (fresh[i]) pending_results.push_back(fresh[i]);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction. Every item goes through the planning copy of the
  // state so the next item can be chosen to keep the transfer going.
  // ---------------------------------------------------------------------------

  // An item with every field random; the caller fixes the ones that matter.
  function automatic in_item_t any_item(input logic [2:0] f);
    in_item_t it;
    it.func             = f;
    it.device_address   = 7'($urandom);
    it.register_address = 16'($urandom);
    it.byte_count       = 16'($urandom);
    it.payload_byte     = 8'($urandom);
    it.reply_status     = 1'($urandom);
    it.read_byte        = 8'($urandom);
    return it;
  endfunction

  task automatic push(input in_item_t it);
    queued_items.push_back(it);
    plan_scratch.delete();
    sequencer_step(seq_plan, it, plan_scratch);
  endtask

  task automatic send_begin(input logic rd, input logic [6:0] dev, input logic [15:0] ra,
                            input logic [15:0] n);
    in_item_t it;
    it = any_item(rd ? FN_READ : FN_WRITE);
    it.device_address   = dev;
    it.register_address = ra;
    it.byte_count       = n;
    push(it);
  endtask

  task automatic send_reply(input logic fault, input logic [7:0] b);
    in_item_t it;
    it = any_item(FN_REPLY);
    it.reply_status = fault;
    it.read_byte    = b;
    push(it);
  endtask

  task automatic send_payload(input logic [7:0] b);
    in_item_t it;
    it = any_item(FN_PAYLOAD);
    it.payload_byte = b;
    push(it);
  endtask

  // One transfer with random content. Most run to completion; some end on a
  // fault or a tick timeout at a random step, and long ones always do, since
  // their byte counts are far too large to finish.
  task automatic random_transfer();
    logic        rd;
    logic [15:0] n;
    int          kind;
    int          abort_at;
    int          steps;
    int          pick;
    rd   = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick == 0) n = '0;
    else if (pick <= 2) n = 16'($urandom);
    else n = 16'($urandom_range(4, 1));
    pick = $urandom_range(9);
    kind = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
    if (n > 6 && kind == 0) kind = 1;
    // Timeouts are only reachable with a short limit.
    if (kind == 2 && seq_plan.limit > 16) kind = 1;
    abort_at = $urandom_range(14);
    steps    = 0;
    send_begin(rd, 7'($urandom), 16'($urandom), n);
    while (seq_plan.phase != S_IDLE) begin
      if ($urandom_range(15) == 0) begin
        // Stray item of any kind in the middle of a transfer.
        push(any_item(3'($urandom_range(FN_SPARE_HI))));
      end else if (seq_plan.phase == S_NEED_PAY) begin
        send_payload(8'($urandom));
      end else begin
        // Ticks that stay under the limit.
        while ($urandom_range(2) == 0 && seq_plan.ticks + 1 < seq_plan.limit)
          push(any_item(FN_TICK));
        if ((kind != 0 && steps >= abort_at) || steps > 40) begin
          if (kind == 2) begin
            while (seq_plan.phase != S_IDLE) push(any_item(FN_TICK));
          end else begin
            send_reply(1'b1, 8'($urandom));
          end
        end else begin
          send_reply(1'b0, 8'($urandom));
        end
        steps++;
      end
    end
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    start = queued_items.size();
    while (queued_items.size() - start < n_items) begin
      // Now and then, items the idle block must ignore.
      if ($urandom_range(7) == 0) push(any_item(3'($urandom_range(FN_SPARE_HI, FN_PAYLOAD))));
      random_transfer();
    end
  endtask

  // Holds off until everything offered is taken and every result is in.
  task automatic wait_for_quiet();
    while (queued_items.size() != 0 || drv_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The limit is only changed with the block idle, so both copies of the
  // state pick it up at once.
  task automatic set_timeout_limit(input logic [23:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    seq_model.limit = v;
    seq_plan.limit  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    seq_model = reset_state();
    seq_plan  = reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the limit left by reset. Items that the idle block
    // should ignore come first: a tick, a spare code, a payload and a reply.
    push(any_item(FN_TICK));
    push(any_item(FN_SPARE_LO));
    send_payload(8'h00);
    send_reply(1'b0, 8'hFF);
    // A read of nothing is refused.
    send_begin(1'b1, 7'h7F, 16'hFFFF, 16'h0000);
    // A write of nothing at the top address, with a counted tick, and a begin
    // while busy that must be dropped.
    send_begin(1'b0, 7'h7F, 16'hFFFF, 16'h0000);
    push(any_item(FN_TICK));
    send_begin(1'b1, 7'h00, 16'h0000, 16'h0005);
    repeat (6) send_reply(1'b0, 8'h00);
    wait_for_quiet();

    // With a limit of one tick, every tick during a wait ends the transfer.
    set_timeout_limit(24'd1);
    // Timeout while waiting for the bus to go idle: no stop.
    send_begin(1'b0, 7'h00, 16'h0000, 16'h0001);
    push(any_item(FN_TICK));
    // Fault while waiting for idle, on the longest read: no stop either.
    send_begin(1'b1, 7'h2A, 16'h8001, 16'hFFFF);
    send_reply(1'b1, 8'h00);
    // Fault while waiting for the transfer to finish reports a timeout.
    send_begin(1'b0, 7'h55, 16'h1234, 16'h0000);
    repeat (5) send_reply(1'b0, 8'h00);
    send_reply(1'b1, 8'h00);
    wait_for_quiet();

    // Random part over several limits. The widest limit phase also carries
    // the long result-side stall, so the buffer fills and stalls the input.
    set_timeout_limit(24'd2);
    random_phase(60);
    wait_for_quiet();

    set_timeout_limit(24'hFF_FFFF);
    hold_go = 1'b1;
    random_phase(60);
    wait_for_quiet();

    // No idling on either side in this phase.
    set_timeout_limit(24'($urandom_range(8, 3)));
    calm = 1'b1;
    random_phase(60);
    wait_for_quiet();
    calm = 1'b0;

    set_timeout_limit(24'($urandom_range(12, 1)));
    random_phase(60);
    wait_for_quiet();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
